FILE: sv/hdlc_txf_pkg.sv
// package for the hdlc transmit framer: queue entry type, back-end states,
// line constants and the crc-16 step function; no dependencies
package hdlc_txf_pkg;

    // line and fcs constants
    localparam logic [7:0]  FLAG_BYTE  = 8'h7E;
    localparam logic [15:0] CRC_POLY   = 16'h1021;
    localparam logic [15:0] CRC_PRESET = 16'hFFFF;

    // bit counter covers the sixteen fcs bits plus one stuffed zero
    localparam int CNT_W = 5;
    localparam logic [CNT_W-1:0] DATA_LAST_BIT = 5'd7;
    localparam logic [CNT_W-1:0] DATA_BITS     = 5'd8;
    localparam logic [CNT_W-1:0] FCS_LAST_BIT  = 5'd15;
    localparam logic [CNT_W-1:0] FCS_BITS      = 5'd16;

    // a stuffed zero follows a one sent while this many ones are already counted
    localparam logic [2:0] ONES_BEFORE_STUFF = 3'd4;

    localparam int QUEUE_DEPTH_DEF = 2;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       opens;
    } txf_entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OPEN,
        ST_DATA,
        ST_FCS,
        ST_CLOSE
    } txf_state_t;

    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic bit_in);
        logic fb;
        fb = crc[15] ^ bit_in;
        crc_step = {crc[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    endfunction

endpackage

FILE: sv/hdlc_txf_front.sv
// front end of the hdlc transmit framer: accepts items, marks frame openers
// and holds them in a short queue; depends on hdlc_txf_pkg
module hdlc_txf_front
    import hdlc_txf_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output logic       q_valid,
    output txf_entry_t q_entry,
    input  logic       q_pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_QW-1:0] FULL_CNT = CNT_QW'(QUEUE_DEPTH);

    txf_entry_t mem [QUEUE_DEPTH];

    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_QW-1:0] count_reg, count_next;
    logic              in_frame_reg, in_frame_next;
    logic              push;
    logic              pop;

    assign in_stall = (count_reg == FULL_CNT);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != '0);
    assign pop      = q_pop && q_valid;
    assign q_entry  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next   = wr_ptr_reg;
        rd_ptr_next   = rd_ptr_reg;
        count_next    = count_reg;
        in_frame_next = in_frame_reg;
        if (push)
        begin
            wr_ptr_next   = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            in_frame_next = !last_byte;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            count_reg    <= '0;
            in_frame_reg <= 1'b0;
        end
        else
        begin
            wr_ptr_reg   <= wr_ptr_next;
            rd_ptr_reg   <= rd_ptr_next;
            count_reg    <= count_next;
            in_frame_reg <= in_frame_next;
        end
    end

    // queue storage, no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= '{data: data_byte, last: last_byte, opens: !in_frame_reg};
        end
    end

endmodule

FILE: sv/hdlc_txf_back.sv
// back end of the hdlc transmit framer: flag, data and fcs serializer with
// crc, bit stuffing and an output register; depends on hdlc_txf_pkg
module hdlc_txf_back
    import hdlc_txf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    input  txf_entry_t q_entry,
    output logic       q_pop,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       line_bit,
    output logic       run_last,
    output logic       frame_end
);

    txf_state_t       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [7:0]       byte_reg, byte_next;
    logic             last_reg, last_next;
    logic [15:0]      crc_reg, crc_next;
    logic [2:0]       ones_reg, ones_next;
    logic             pend_reg, pend_next;

    logic out_valid_reg, out_valid_next;
    logic line_bit_reg, line_bit_next;
    logic run_last_reg, run_last_next;
    logic frame_end_reg, frame_end_next;

    logic out_free;
    logic emit;
    logic ebit;
    logic erl;
    logic efe;
    logic done;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        crc_next   = crc_reg;
        ones_next  = ones_reg;
        pend_next  = pend_reg;
        q_pop      = 1'b0;
        emit       = 1'b0;
        ebit       = 1'b0;
        erl        = 1'b0;
        efe        = 1'b0;
        done       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    byte_next = q_entry.data;
                    last_next = q_entry.last;
                    cnt_next  = '0;
                    pend_next = 1'b0;
                    if (q_entry.opens)
                    begin
                        state_next = ST_OPEN;
                        crc_next   = CRC_PRESET;
                        ones_next  = '0;
                    end
                    else
                    begin
                        state_next = ST_DATA;
                    end
                end
            end
            ST_OPEN, ST_CLOSE:
            begin
                if (out_free)
                begin
                    emit     = 1'b1;
                    ebit     = FLAG_BYTE[3'd7 - cnt_reg[2:0]];
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == DATA_LAST_BIT)
                    begin
                        cnt_next = '0;
                        if (state_reg == ST_OPEN)
                        begin
                            state_next = ST_DATA;
                        end
                        else
                        begin
                            // frame closed: back to reset state
                            efe        = 1'b1;
                            erl        = 1'b1;
                            state_next = ST_IDLE;
                            crc_next   = CRC_PRESET;
                            ones_next  = '0;
                        end
                    end
                end
            end
            ST_DATA, ST_FCS:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    if (pend_reg)
                    begin
                        // stuffed zero
                        ebit      = 1'b0;
                        pend_next = 1'b0;
                        done      = (state_reg == ST_DATA) ? (cnt_reg == DATA_BITS)
                                                           : (cnt_reg == FCS_BITS);
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                        if (state_reg == ST_DATA)
                        begin
                            ebit      = byte_reg[7];
                            byte_next = {byte_reg[6:0], 1'b0};
                            crc_next  = crc_step(crc_reg, byte_reg[7]);
                        end
                        else
                        begin
                            ebit     = crc_reg[15];
                            crc_next = {crc_reg[14:0], 1'b0};
                        end
                        if (ebit)
                        begin
                            if (ones_reg == ONES_BEFORE_STUFF)
                            begin
                                pend_next = 1'b1;
                                ones_next = '0;
                            end
                            else
                            begin
                                ones_next = ones_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            ones_next = '0;
                        end
                        done = ((state_reg == ST_DATA) ? (cnt_reg == DATA_LAST_BIT)
                                                       : (cnt_reg == FCS_LAST_BIT))
                               && !pend_next;
                    end
                    if (done)
                    begin
                        cnt_next = '0;
                        if (state_reg == ST_FCS)
                        begin
                            state_next = ST_CLOSE;
                        end
                        else if (last_reg)
                        begin
                            state_next = ST_FCS;
                        end
                        else
                        begin
                            erl        = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        line_bit_next  = line_bit_reg;
        run_last_next  = run_last_reg;
        frame_end_next = frame_end_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            line_bit_next  = ebit;
            run_last_next  = erl;
            frame_end_next = efe;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            crc_reg       <= CRC_PRESET;
            ones_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            crc_reg       <= crc_next;
            ones_reg      <= ones_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        byte_reg      <= byte_next;
        last_reg      <= last_next;
        line_bit_reg  <= line_bit_next;
        run_last_reg  <= run_last_next;
        frame_end_reg <= frame_end_next;
    end

    assign out_valid = out_valid_reg;
    assign line_bit  = line_bit_reg;
    assign run_last  = run_last_reg;
    assign frame_end = frame_end_reg;

endmodule

FILE: sv/hdlc_transmit_framer_unit.sv
// top level of the hdlc transmit framer (crc-16/ccitt fcs, bit stuffing)
// depends on hdlc_txf_pkg, hdlc_txf_front and hdlc_txf_back
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-----------------------------
//   in      | input     | in_valid, in_stall   | data_byte[7:0], last_byte
//   out     | output    | out_valid, out_stall | line_bit, run_last, frame_end
//
// at most one line bit leaves per cycle, none while out_stall holds it; a byte is
// loaded into the serializer, then sends its 8 data bits and up to two stuffed zeros
// a frame opener adds an 8-bit opening flag, a last byte adds 16 fcs bits, their
// stuffed zeros and an 8-bit closing flag; the serializer sets the pace
// reset (rst_n, async, low) empties the queue and returns to between frames
// out_stall freezes the output register and serializer while out_valid is high;
// in_stall rises only when the item queue is full
module hdlc_transmit_framer_unit
    import hdlc_txf_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       line_bit,
    output logic       run_last,
    output logic       frame_end
);

    // queued item with its frame-opener mark from the front end
    txf_entry_t q_entry;
    logic       q_valid;
    logic       q_pop;

    // front: accepts items, tracks frame boundaries, buffers them
    hdlc_txf_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .q_valid   (q_valid),
        .q_entry   (q_entry),
        .q_pop     (q_pop)
    );

    // back: flags, data bits with crc and stuffing, fcs, closing flag
    hdlc_txf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_entry   (q_entry),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .line_bit  (line_bit),
        .run_last  (run_last),
        .frame_end (frame_end)
    );

endmodule

FILE: dv/hdlc_txf_checker.sv
// line checker for the hdlc transmit framer: predicts the serial bits of each
// accepted byte and compares them with the output channel
// depends on hdlc_txf_pkg
module hdlc_txf_checker
    import hdlc_txf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic       line_bit,
    input  logic       run_last,
    input  logic       frame_end,
    output int         fail_count,
    output int         bits_owed,
    output int         bits_checked,
    output int         frames_done
);

    localparam logic [2:0] STUFF_RUN = 3'd5;

    typedef struct packed {
        logic bit_val;
        logic run_last;
        logic frame_end;
    } line_sym_t;

    line_sym_t  owed_bits[$];
    logic       frame_open;
    logic [15:0] fcs_reg;
    logic [2:0] ones_cnt;
    int         miss_cnt;
    int         checked_cnt;
    int         frame_cnt;
    line_sym_t  got;
    line_sym_t  want;

    function void push_line_bit(input logic b, input logic fe);
        line_sym_t s;
        s.bit_val   = b;
        s.run_last  = 1'b0;
        s.frame_end = fe;
        owed_bits.insert(owed_bits.size(), s);
    endfunction

    function void push_flag(input logic closing);
        for (int i = 7; i >= 0; i--)
            push_line_bit(FLAG_BYTE[i], closing && (i == 0));
    endfunction

    function void push_stuffed(input logic b);
        push_line_bit(b, 1'b0);
        if (!b)
            ones_cnt = 3'd0;
        else
        begin
            ones_cnt = ones_cnt + 3'd1;
            if (ones_cnt >= STUFF_RUN)
            begin
                push_line_bit(1'b0, 1'b0);
                ones_cnt = 3'd0;
            end
        end
    endfunction

    function void fold_crc(input logic b);
        logic fb;
        fb = fcs_reg[15] ^ b;
        fcs_reg = {fcs_reg[14:0], 1'b0};
        if (fb)
            fcs_reg = fcs_reg ^ CRC_POLY;
    endfunction

    function void predict_byte(input logic [7:0] b, input logic lst);
        logic [15:0] fcs_snap;
        line_sym_t   tail;
        if (!frame_open)
        begin
            push_flag(1'b0);
            frame_open = 1'b1;
            fcs_reg    = CRC_PRESET;
            ones_cnt   = 3'd0;
        end
        for (int i = 7; i >= 0; i--)
        begin
            fold_crc(b[i]);
            push_stuffed(b[i]);
        end
        if (lst)
        begin
            fcs_snap = fcs_reg;
            for (int i = 15; i >= 0; i--)
                push_stuffed(fcs_snap[i]);
            push_flag(1'b1);
            frame_open = 1'b0;
            fcs_reg    = CRC_PRESET;
            ones_cnt   = 3'd0;
        end
        tail = owed_bits[owed_bits.size() - 1];
        tail.run_last = 1'b1;
        owed_bits[owed_bits.size() - 1] = tail;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owed_bits.delete();
            frame_open   = 1'b0;
            fcs_reg      = CRC_PRESET;
            ones_cnt     = 3'd0;
            miss_cnt     = 0;
            checked_cnt  = 0;
            frame_cnt    = 0;
            fail_count   <= 0;
            bits_owed    <= 0;
            bits_checked <= 0;
            frames_done  <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                predict_byte(data_byte, last_byte);
            if (out_valid && !out_stall)
            begin
                got.bit_val   = line_bit;
                got.run_last  = run_last;
                got.frame_end = frame_end;
                if (owed_bits.size() == 0)
                begin
                    miss_cnt++;
                    if (miss_cnt <= 10)
                        $display("unexpected line bit %b run_last=%b frame_end=%b",
                                 got.bit_val, got.run_last, got.frame_end);
                end
                else
                begin
                    want = owed_bits.pop_front();
                    if (got.bit_val !== want.bit_val || got.run_last !== want.run_last
                        || got.frame_end !== want.frame_end)
                    begin
                        miss_cnt++;
                        if (miss_cnt <= 10)
                            $display("line bit %0d: expected %b/%b/%b got %b/%b/%b",
                                     checked_cnt, want.bit_val, want.run_last,
                                     want.frame_end, got.bit_val, got.run_last,
                                     got.frame_end);
                    end
                    if (want.frame_end)
                        frame_cnt++;
                end
                checked_cnt++;
            end
            fail_count   <= miss_cnt;
            bits_owed    <= owed_bits.size();
            bits_checked <= checked_cnt;
            frames_done  <= frame_cnt;
        end
    end

endmodule

FILE: dv/tb.sv
// top of the hdlc transmit framer bench: clock, reset, byte stimulus and
// output stall; depends on hdlc_transmit_framer_unit, hdlc_txf_checker
module tb;

    // leave plenty of room for the worst case with every bit stalled
    localparam int CYCLE_LIMIT  = 1500000;
    localparam int TOTAL_ITEMS  = 380;
    // quiet cycles after the last expected bit to catch stray output
    localparam int TAIL_CYCLES  = 64;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] data_byte = 8'h00;
    logic       last_byte = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       line_bit;
    logic       run_last;
    logic       frame_end;

    int fail_count;
    int bits_owed;
    int bits_checked;
    int frames_done;

    int  cycle_count = 0;
    int  bytes_sent = 0;
    int  stall_left = 0;
    int  stall_draw;
    logic tx_burst = 1'b0;   // no gaps between items while set
    logic rx_free = 1'b0;    // no output stalls while set

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    hdlc_transmit_framer_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .line_bit  (line_bit),
        .run_last  (run_last),
        .frame_end (frame_end)
    );

    hdlc_txf_checker line_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .line_bit     (line_bit),
        .run_last     (run_last),
        .frame_end    (frame_end),
        .fail_count   (fail_count),
        .bits_owed    (bits_owed),
        .bits_checked (bits_checked),
        .frames_done  (frames_done)
    );

    // receiver: after each accepted bit draw a random stall, none while rx_free is set
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (out_stall)
        begin
            if (stall_left == 0)
                out_stall <= 1'b0;
            else
                stall_left <= stall_left - 1;
        end
        else if (out_valid && !rx_free)
        begin
            stall_draw = $urandom_range(0, 16);
            if (stall_draw > 0)
            begin
                out_stall  <= 1'b1;
                stall_left <= stall_draw - 1;
            end
        end
    end

    // run watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d bits still owed", cycle_count, bits_owed);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // hand one byte to the framer; valid stays up across back-to-back items
    task automatic send_byte(input logic [7:0] b, input logic lst);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last_byte <= lst;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bytes_sent++;
    endtask

    // bytes biased toward long runs of ones so stuffing gets exercised
    function automatic logic [7:0] pick_byte();
        logic [7:0] v;
        case ($urandom_range(0, 7))
            0: v = 8'hFF;
            1: v = 8'h7E;
            2: v = 8'h00;
            3: v = {3'($urandom_range(0, 7)), 5'h1F};
            default: v = 8'($urandom_range(0, 255));
        endcase
        return v;
    endfunction

    initial
    begin
        int frame_len;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // one-byte frames at both extremes of the data field
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        // long runs of ones force stuffed zeros, a flag pattern inside data
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h7E, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'h7E, 1'b1);
        // runs of ones that straddle byte boundaries
        send_byte(8'h1F, 1'b0);
        send_byte(8'hF8, 1'b0);
        send_byte(8'h3E, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h80, 1'b1);
        // alternating bits, no stuffing in data
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b1);
        // back-to-back frames with no gaps and no stalls
        tx_burst = 1'b1;
        rx_free  <= 1'b1;
        send_byte(8'hFF, 1'b1);
        send_byte(8'hC3, 1'b0);
        send_byte(8'h3C, 1'b1);

        // random frames, mostly short, now and then long
        while (bytes_sent < TOTAL_ITEMS)
        begin
            tx_burst = ($urandom_range(0, 3) == 0);
            rx_free  <= ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 7) == 0)
                frame_len = $urandom_range(9, 24);
            else
                frame_len = $urandom_range(1, 8);
            for (int k = 0; k < frame_len; k++)
                send_byte(pick_byte(), k == frame_len - 1);
        end
        in_valid <= 1'b0;
        rx_free  <= 1'b0;

        // drain, then give the framer time to show any extra bits
        @(posedge clk);
        while (bits_owed != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("sent %0d bytes in %0d frames, checked %0d line bits",
                 bytes_sent, frames_done, bits_checked);
        $display("random gaps and stalls of 0 to 16 cycles, %0d mismatches", fail_count);
        if (fail_count == 0 && bits_owed == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
